@@ rtl/ssd_pkg.sv @@
// Shared types, constants and coefficient table for the SOQPSK symbol detector.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

    localparam int FILTER_TAPS = 20;
    localparam int HALF_TAPS   = FILTER_TAPS / 2;
    localparam int DL_DEPTH    = FILTER_TAPS - 2;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int SOFT_W      = 18;
    localparam int GAIN_W      = 18;
    localparam int ERR_W       = 20;
    localparam int INTEG_W     = 24;
    localparam int MU_W        = 16;
    localparam int NCO_W       = 17;
    localparam int ANG_W       = 16;
    localparam int MUL_W       = 22;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int WIDE_W      = 48;
    localparam int IDX_W       = 4;
    localparam int FAR_STEPS   = 8;
    localparam int DIV_STEPS   = 16;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_PROP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_LAG  = 2'd3;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILT,
        OP_FACC,
        OP_FRND,
        OP_ROTA,
        OP_ROTB,
        OP_ROTC,
        OP_FAR,
        OP_ERR,
        OP_NOERR,
        OP_LOOPA,
        OP_LOOPB,
        OP_LOOPC,
        OP_LOOPD,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic strobe;
        logic wrap;
        logic out_busy;
    } t_stat;

    // detection filter half, round(c * 2^17)
    function automatic logic signed [COEF_W-1:0] coef(input logic [IDX_W-1:0] idx);
        case (idx)
            4'd0:    return 18'sd1360;
            4'd1:    return 18'sd3105;
            4'd2:    return 18'sd1280;
            4'd3:    return -18'sd3541;
            4'd4:    return -18'sd11765;
            4'd5:    return -18'sd14463;
            4'd6:    return -18'sd6797;
            4'd7:    return 18'sd20306;
            4'd8:    return 18'sd74573;
            4'd9:    return 18'sd103861;
            default: return 18'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/soqpsk_symbol_detector.sv @@
// Output: the decision step of an item loads its result into the output register; that step
//   waits while the previous result still waits downstream.
// Sequence: one item at a time, through the 10-step filter MAC, the 8-step Farrow pass
//   with a strobe pending, and the 16-step bit-serial divider when the NCO wraps.
// Reset: synchronous active low; clears filter/interpolator history, loop state,
//   gains and the output valid; the sine table is constant logic.
`timescale 1ns / 1ps
`default_nettype none
module soqpsk_symbol_detector #(
    parameter int SINCOS_DEPTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // i_first[15:0], q_first[31:16], i_second[47:32], q_second[63:48]
    input  wire logic [ssd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // soft_i[17:0], soft_q[35:18], bit_even[36], bit_odd[37], zero[39:38]
    output logic [ssd_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssd_pkg::GAIN_W-1:0]     i_cfg_data
);

    logic           w_accept;
    ssd_pkg::t_cmd  w_cmd;
    ssd_pkg::t_stat w_stat;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    ssd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_ready  (o_s_axis_tready)
    );

    ssd_datapath #(
        .SINCOS_DEPTH (SINCOS_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capture   (w_accept),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    // an accepted item closes the input until the sequence ends
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input ready stayed high after an accepted item");

    // a result appears only from the error/decision step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_cmd.op == ssd_pkg::OP_ERR))
        else $error("result loaded outside the decision step");

    // the divider runs only after an NCO wrap set the strobe
    a_div_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == ssd_pkg::OP_DIV) |-> w_stat.strobe)
        else $error("divider running without a strobe");
`endif

endmodule
`default_nettype wire

@@ rtl/ssd_ctrl.sv @@
// Step sequencer for the symbol detector: issues one datapath operation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ssd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire ssd_pkg::t_stat i_stat,
    output ssd_pkg::t_cmd      o_cmd,
    output logic               o_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_FILT, S_FACC, S_FRND, S_ROTA, S_ROTB, S_ROTC,
        S_FAR, S_ERR, S_NOERR, S_LOOPA, S_LOOPB, S_LOOPC, S_LOOPD, S_DIV
    } t_state;

    t_state        r_state;
    ssd_pkg::t_cmd r_cmd;
    logic          r_ready;

    assign o_cmd   = r_cmd;
    assign o_ready = r_ready;

    // state, command and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmd.op  <= ssd_pkg::OP_NONE;
            r_cmd.idx <= '0;
            r_ready   <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_state   <= S_LOAD;
                        r_cmd.op  <= ssd_pkg::OP_LOAD;
                        r_cmd.idx <= '0;
                        r_ready   <= 1'b0;
                    end
                end
                S_LOAD: begin
                    r_state   <= S_FILT;
                    r_cmd.op  <= ssd_pkg::OP_FILT;
                    r_cmd.idx <= '0;
                end
                S_FILT: begin
                    if (r_cmd.idx == ssd_pkg::IDX_W'(ssd_pkg::HALF_TAPS - 1)) begin
                        r_state  <= S_FACC;
                        r_cmd.op <= ssd_pkg::OP_FACC;
                    end else begin
                        r_cmd.idx <= r_cmd.idx + 1'b1;
                    end
                end
                S_FACC: begin
                    r_state  <= S_FRND;
                    r_cmd.op <= ssd_pkg::OP_FRND;
                end
                S_FRND: begin
                    r_state  <= S_ROTA;
                    r_cmd.op <= ssd_pkg::OP_ROTA;
                end
                S_ROTA: begin
                    r_state  <= S_ROTB;
                    r_cmd.op <= ssd_pkg::OP_ROTB;
                end
                S_ROTB: begin
                    r_state  <= S_ROTC;
                    r_cmd.op <= ssd_pkg::OP_ROTC;
                end
                S_ROTC: begin
                    // interpolants only on a pending strobe
                    if (i_stat.strobe) begin
                        r_state   <= S_FAR;
                        r_cmd.op  <= ssd_pkg::OP_FAR;
                        r_cmd.idx <= '0;
                    end else begin
                        r_state  <= S_NOERR;
                        r_cmd.op <= ssd_pkg::OP_NOERR;
                    end
                end
                S_FAR: begin
                    if (r_cmd.idx == ssd_pkg::IDX_W'(ssd_pkg::FAR_STEPS - 1)) begin
                        r_state  <= S_ERR;
                        r_cmd.op <= ssd_pkg::OP_ERR;
                    end else begin
                        r_cmd.idx <= r_cmd.idx + 1'b1;
                    end
                end
                S_ERR: begin
                    // hold until the output register is free
                    if (!i_stat.out_busy) begin
                        r_state  <= S_LOOPA;
                        r_cmd.op <= ssd_pkg::OP_LOOPA;
                    end
                end
                S_NOERR: begin
                    r_state  <= S_LOOPA;
                    r_cmd.op <= ssd_pkg::OP_LOOPA;
                end
                S_LOOPA: begin
                    r_state  <= S_LOOPB;
                    r_cmd.op <= ssd_pkg::OP_LOOPB;
                end
                S_LOOPB: begin
                    r_state  <= S_LOOPC;
                    r_cmd.op <= ssd_pkg::OP_LOOPC;
                end
                S_LOOPC: begin
                    r_state  <= S_LOOPD;
                    r_cmd.op <= ssd_pkg::OP_LOOPD;
                end
                S_LOOPD: begin
                    if (i_stat.wrap) begin
                        r_state   <= S_DIV;
                        r_cmd.op  <= ssd_pkg::OP_DIV;
                        r_cmd.idx <= '0;
                    end else begin
                        r_state  <= S_IDLE;
                        r_cmd.op <= ssd_pkg::OP_NONE;
                        r_ready  <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cmd.idx == ssd_pkg::IDX_W'(ssd_pkg::DIV_STEPS - 1)) begin
                        r_state  <= S_IDLE;
                        r_cmd.op <= ssd_pkg::OP_NONE;
                        r_ready  <= 1'b1;
                    end else begin
                        r_cmd.idx <= r_cmd.idx + 1'b1;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_cmd.op <= ssd_pkg::OP_NONE;
                    r_ready  <= 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/ssd_datapath.sv @@
// Datapath: filter MAC, rotation, Farrow interpolation, loop filters, NCO and divider.
`timescale 1ns / 1ps
`default_nettype none
module ssd_datapath #(
    parameter int SINCOS_DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_capture,
    input  wire logic [ssd_pkg::IN_DATA_W-1:0]    i_in_data,
    input  wire ssd_pkg::t_cmd                    i_cmd,
    output ssd_pkg::t_stat                        o_stat,
    input  wire logic                             i_cfg_we,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ssd_pkg::GAIN_W-1:0]       i_cfg_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [ssd_pkg::OUT_DATA_W-1:0]        o_out_data
);

    localparam int Quarter = SINCOS_DEPTH / 4;
    localparam int K_W     = $clog2(SINCOS_DEPTH);
    localparam int QI_W    = $clog2(Quarter + 1);
    localparam int KP_W    = ssd_pkg::ANG_W + $clog2(SINCOS_DEPTH + 1);
    localparam logic [63:0] OneQ30    = 64'd1 << 30;
    localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

    localparam int SW = ssd_pkg::SAMPLE_W;
    localparam int MW = ssd_pkg::MUL_W;
    localparam int WW = ssd_pkg::WIDE_W;
    localparam int FW = ssd_pkg::SOFT_W;
    localparam int EW = ssd_pkg::ERR_W;
    localparam int IW = ssd_pkg::INTEG_W;

    // quarter-wave sine, Q1.16, from an integer Taylor series
    function automatic logic [16:0] quarter_sin(input int m);
        logic [63:0] x, x2, f, s;
        x  = (64'(m) * PiHalfQ30) / 64'(Quarter);
        x2 = (x * x) >> 30;
        f  = OneQ30 - x2 / 64'd110;
        f  = OneQ30 - ((x2 * f) >> 30) / 64'd72;
        f  = OneQ30 - ((x2 * f) >> 30) / 64'd42;
        f  = OneQ30 - ((x2 * f) >> 30) / 64'd20;
        f  = OneQ30 - ((x2 * f) >> 30) / 64'd6;
        s  = (x * f) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) s = 64'd65536;
        return s[16:0];
    endfunction

    // quadrant folding: returns {negate, quarter-table index}
    function automatic logic [QI_W:0] sin_index(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        logic           neg;
        logic           mir;
        if (k >= K_W'(3 * Quarter)) begin
            r = k - K_W'(3 * Quarter); neg = 1'b1; mir = 1'b1;
        end else if (k >= K_W'(2 * Quarter)) begin
            r = k - K_W'(2 * Quarter); neg = 1'b1; mir = 1'b0;
        end else if (k >= K_W'(Quarter)) begin
            r = k - K_W'(Quarter); neg = 1'b0; mir = 1'b1;
        end else begin
            r = k; neg = 1'b0; mir = 1'b0;
        end
        if (mir) return {neg, QI_W'(K_W'(Quarter) - r)};
        return {neg, QI_W'(r)};
    endfunction

    function automatic logic signed [FW-1:0] sat18(input logic signed [WW-1:0] v);
        if (v > 48'sd131071) return 18'sd131071;
        if (v < -48'sd131072) return -18'sd131072;
        return v[FW-1:0];
    endfunction

    function automatic logic signed [IW-1:0] sat24(input logic signed [WW-1:0] v);
        if (v > 48'sd8388607) return 24'sd8388607;
        if (v < -48'sd8388608) return -24'sd8388608;
        return v[IW-1:0];
    endfunction

    function automatic logic signed [FW-1:0] neg_half(input logic signed [FW-1:0] v);
        logic signed [FW:0] t;
        t = (-(19'(v)) + 19'sd1) >>> 1;
        return t[FW-1:0];
    endfunction

    // constant quarter table
    logic [16:0] w_qsin [Quarter + 1];
    for (genvar g = 0; g <= Quarter; g++) begin : g_qsin
        assign w_qsin[g] = quarter_sin(g);
    end

    // configuration
    logic signed [ssd_pkg::GAIN_W-1:0] r_pg_prop, r_pg_lag, r_tg_prop, r_tg_lag;

    // captured item and filter state
    logic signed [SW-1:0] r_i1, r_q1, r_i2, r_q2;
    logic signed [SW-1:0] r_dl_i [ssd_pkg::DL_DEPTH];
    logic signed [SW-1:0] r_dl_q [ssd_pkg::DL_DEPTH];
    logic signed [SW:0]   r_ps_i [ssd_pkg::HALF_TAPS];
    logic signed [SW:0]   r_ps_q [ssd_pkg::HALF_TAPS];
    logic signed [SW:0]   n_ps_i [ssd_pkg::HALF_TAPS];
    logic signed [SW:0]   n_ps_q [ssd_pkg::HALF_TAPS];
    logic signed [WW-1:0] r_acc_i, r_acc_q;
    logic signed [FW-1:0] r_x, r_y, r_xr, r_yr;
    logic signed [FW-1:0] r_sin, r_cos;

    // interpolator state
    logic signed [FW-1:0] r_fx [9];
    logic signed [FW-1:0] r_fy [7];
    logic signed [MW-1:0] r_t1, r_t2;
    logic signed [FW-1:0] r_yi, r_xi1, r_yi1, r_xi2;
    logic signed [FW-1:0] r_sx, r_sy;
    logic                 r_prev;

    // loop state
    logic signed [EW-1:0] r_et, r_ep, r_tle, r_ple;
    logic signed [IW-1:0] r_ti, r_pi;
    logic                 r_strobe;
    logic [ssd_pkg::MU_W-1:0]  r_mu;
    logic [ssd_pkg::NCO_W-1:0] r_nco, r_w, r_rem;
    logic [ssd_pkg::ANG_W-1:0] r_angle;

    // shared multipliers
    logic signed [MW-1:0] w_a1, w_b1, w_a2, w_b2;
    logic signed [ssd_pkg::PROD_W-1:0] r_p1, r_p2;

    logic                               r_out_valid;
    logic [ssd_pkg::OUT_DATA_W-1:0]     r_out_data;

    // ---- symmetric pre-sums of the filter window
    always_comb begin
        for (int j = 0; j < ssd_pkg::HALF_TAPS; j++) begin
            if (j == 0) begin
                n_ps_i[j] = 17'(r_i2) + 17'(r_dl_i[ssd_pkg::DL_DEPTH - 1]);
                n_ps_q[j] = 17'(r_q2) + 17'(r_dl_q[ssd_pkg::DL_DEPTH - 1]);
            end else if (j == 1) begin
                n_ps_i[j] = 17'(r_i1) + 17'(r_dl_i[ssd_pkg::DL_DEPTH - 2]);
                n_ps_q[j] = 17'(r_q1) + 17'(r_dl_q[ssd_pkg::DL_DEPTH - 2]);
            end else begin
                n_ps_i[j] = 17'(r_dl_i[j - 2]) + 17'(r_dl_i[ssd_pkg::FILTER_TAPS - 3 - j]);
                n_ps_q[j] = 17'(r_dl_q[j - 2]) + 17'(r_dl_q[ssd_pkg::FILTER_TAPS - 3 - j]);
            end
        end
    end

    // ---- sine/cosine lookup from the carrier angle
    logic [KP_W-1:0] w_kprod;
    logic [K_W-1:0]  w_k, w_kc;
    logic [K_W:0]    w_kq;
    logic [QI_W:0]   w_sidx, w_cidx;
    logic signed [FW-1:0] w_sin, w_cos;

    always_comb begin
        w_kprod = KP_W'(r_angle) * KP_W'(SINCOS_DEPTH);
        w_k     = w_kprod[ssd_pkg::ANG_W +: K_W];
        w_kq    = {1'b0, w_k} + (K_W + 1)'(Quarter);
        if (w_kq >= (K_W + 1)'(SINCOS_DEPTH)) w_kc = K_W'(w_kq - (K_W + 1)'(SINCOS_DEPTH));
        else w_kc = K_W'(w_kq);
        w_sidx = sin_index(w_k);
        w_cidx = sin_index(w_kc);
        w_sin  = w_sidx[QI_W] ? -$signed({1'b0, w_qsin[w_sidx[QI_W-1:0]]})
                              :  $signed({1'b0, w_qsin[w_sidx[QI_W-1:0]]});
        w_cos  = w_cidx[QI_W] ? -$signed({1'b0, w_qsin[w_cidx[QI_W-1:0]]})
                              :  $signed({1'b0, w_qsin[w_cidx[QI_W-1:0]]});
    end

    // ---- Farrow operands
    logic                 w_pass;
    logic [1:0]           w_sub;
    logic signed [MW-1:0] w_ny;
    logic signed [MW-1:0] w_v2a, w_v1a, w_v2b, w_v1b, w_ca, w_cb;

    always_comb begin
        w_pass = i_cmd.idx[2];
        w_sub  = i_cmd.idx[1:0];
        w_ny   = MW'(neg_half(r_yr));
        if (!w_pass) begin
            w_v2a = -w_ny + MW'(r_fy[0]) + MW'(r_fy[1]) - MW'(r_fy[2]);
            w_v1a = w_ny - MW'(r_fy[0]) + MW'(r_fy[4]) + MW'(r_fy[1]) + MW'(r_fy[2]);
            w_ca  = MW'(r_fy[5]);
            w_v2b = -MW'(r_fx[0]) + MW'(r_fx[1]) + MW'(r_fx[2]) - MW'(r_fx[3]);
            w_v1b = MW'(r_fx[0]) - MW'(r_fx[1]) + MW'(r_fx[6]) + MW'(r_fx[2]) + MW'(r_fx[3]);
            w_cb  = MW'(r_fx[7]);
        end else begin
            w_v2a = -MW'(r_fy[0]) + MW'(r_fy[1]) + MW'(r_fy[2]) - MW'(r_fy[3]);
            w_v1a = MW'(r_fy[0]) - MW'(r_fy[1]) + MW'(r_fy[5]) + MW'(r_fy[2]) + MW'(r_fy[3]);
            w_ca  = MW'(r_fy[6]);
            w_v2b = -MW'(r_fx[1]) + MW'(r_fx[2]) + MW'(r_fx[3]) - MW'(r_fx[4]);
            w_v1b = MW'(r_fx[1]) - MW'(r_fx[2]) + MW'(r_fx[7]) + MW'(r_fx[3]) + MW'(r_fx[4]);
            w_cb  = MW'(r_fx[8]);
        end
    end

    // ---- multiplier operand select
    logic signed [MW-1:0] w_mu;
    assign w_mu = $signed(MW'(r_mu));

    always_comb begin
        w_a1 = '0; w_b1 = '0; w_a2 = '0; w_b2 = '0;
        case (i_cmd.op)
            ssd_pkg::OP_FILT: begin
                w_a1 = MW'(ssd_pkg::coef(i_cmd.idx)); w_b1 = MW'(r_ps_i[0]);
                w_a2 = MW'(ssd_pkg::coef(i_cmd.idx)); w_b2 = MW'(r_ps_q[0]);
            end
            ssd_pkg::OP_ROTA: begin
                w_a1 = MW'(r_x); w_b1 = MW'(r_cos);
                w_a2 = MW'(r_y); w_b2 = MW'(r_sin);
            end
            ssd_pkg::OP_ROTB: begin
                w_a1 = MW'(r_y); w_b1 = MW'(r_cos);
                w_a2 = MW'(r_x); w_b2 = MW'(r_sin);
            end
            ssd_pkg::OP_FAR: begin
                if (w_sub == 2'd0) begin
                    w_a1 = w_v2a; w_b1 = w_mu;
                    w_a2 = w_v2b; w_b2 = w_mu;
                end else if (w_sub == 2'd2) begin
                    w_a1 = r_t1; w_b1 = w_mu;
                    w_a2 = r_t2; w_b2 = w_mu;
                end
            end
            ssd_pkg::OP_LOOPA: begin
                w_a1 = MW'(r_tg_prop); w_b1 = MW'(r_et);
                w_a2 = MW'(r_tg_lag);  w_b2 = MW'(r_tle);
            end
            ssd_pkg::OP_LOOPB: begin
                w_a1 = MW'(r_pg_prop); w_b1 = MW'(r_ep);
                w_a2 = MW'(r_pg_lag);  w_b2 = MW'(r_ple);
            end
            default: begin
                w_a1 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= w_a1 * w_b1;
        r_p2 <= w_a2 * w_b2;
    end

    // ---- rounded sums of the registered products
    logic signed [WW-1:0] w_p1, w_p2, w_rnd1, w_rnd2;
    logic signed [WW-1:0] w_rot_add, w_rot_sub, w_loop;
    logic signed [IW-1:0] w_vt, w_vp;
    logic signed [WW-1:0] w_wv;
    logic signed [ssd_pkg::NCO_W+1:0] w_t;

    always_comb begin
        w_p1      = WW'(r_p1);
        w_p2      = WW'(r_p2);
        w_rnd1    = (w_p1 + 48'sd32768) >>> 16;
        w_rnd2    = (w_p2 + 48'sd32768) >>> 16;
        w_rot_add = (w_p1 + w_p2 + 48'sd32768) >>> 16;
        w_rot_sub = (w_p1 - w_p2 + 48'sd32768) >>> 16;
        w_loop    = (w_p1 + w_p2 + 48'sd16384) >>> 15;
        w_vt      = sat24(WW'(r_ti) + w_loop);
        w_vp      = sat24(WW'(r_pi) + w_loop);
        w_wv      = 48'sd32768 + ((WW'(r_ti) + 48'sd128) >>> 8);
        w_t       = $signed({2'b00, r_nco}) - $signed({2'b00, r_w});
    end

    // ---- timing and phase errors, decoded bits
    logic                 w_xpos, w_xneg, w_ypos, w_yneg, w_d0, w_d1;
    logic signed [EW-1:0] w_dx, w_dy, w_et, w_ep, w_tx, w_ty, w_px, w_py;

    always_comb begin
        w_xneg = r_xi2[FW-1];
        w_xpos = !r_xi2[FW-1] && (|r_xi2);
        w_yneg = r_yi1[FW-1];
        w_ypos = !r_yi1[FW-1] && (|r_yi1);
        w_d0   = w_xpos;
        w_d1   = w_ypos;
        w_dx   = EW'(r_xi1) - EW'(r_sx);
        w_dy   = EW'(r_yi) - EW'(r_sy);
        w_tx   = w_xpos ? w_dx : (w_xneg ? -w_dx : '0);
        w_ty   = w_ypos ? w_dy : (w_yneg ? -w_dy : '0);
        w_px   = w_xpos ? EW'(r_sy) : (w_xneg ? -EW'(r_sy) : '0);
        w_py   = w_ypos ? EW'(r_xi1) : (w_yneg ? -EW'(r_xi1) : '0);
        w_et   = w_tx + w_ty;
        w_ep   = w_px - w_py;
    end

    logic w_out_busy;
    assign w_out_busy = r_out_valid && !i_out_ready;

    // ---- divider step
    logic [ssd_pkg::NCO_W:0] w_r2;
    logic                    w_ge;
    assign w_r2 = {r_rem, 1'b0};
    assign w_ge = w_r2 >= {1'b0, r_w};

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg_prop <= '0;
            r_pg_lag  <= '0;
            r_tg_prop <= '0;
            r_tg_lag  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssd_pkg::CFG_PHASE_PROP:  r_pg_prop <= $signed(i_cfg_data);
                ssd_pkg::CFG_PHASE_LAG:   r_pg_lag  <= $signed(i_cfg_data);
                ssd_pkg::CFG_TIMING_PROP: r_tg_prop <= $signed(i_cfg_data);
                ssd_pkg::CFG_TIMING_LAG:  r_tg_lag  <= $signed(i_cfg_data);
                default:                  r_pg_prop <= r_pg_prop;
            endcase
        end
    end

    // ---- item capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_i1 <= $signed(i_in_data[15:0]);
            r_q1 <= $signed(i_in_data[31:16]);
            r_i2 <= $signed(i_in_data[47:32]);
            r_q2 <= $signed(i_in_data[63:48]);
        end
    end

    // ---- working registers (no reset)
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ssd_pkg::OP_LOAD: begin
                r_ps_i  <= n_ps_i;
                r_ps_q  <= n_ps_q;
                r_acc_i <= '0;
                r_acc_q <= '0;
                r_sin   <= w_sin;
                r_cos   <= w_cos;
            end
            ssd_pkg::OP_FILT: begin
                for (int j = 0; j < ssd_pkg::HALF_TAPS - 1; j++) begin
                    r_ps_i[j] <= r_ps_i[j + 1];
                    r_ps_q[j] <= r_ps_q[j + 1];
                end
                if (i_cmd.idx != '0) begin
                    r_acc_i <= r_acc_i + w_p1;
                    r_acc_q <= r_acc_q + w_p2;
                end
            end
            ssd_pkg::OP_FACC: begin
                r_acc_i <= r_acc_i + w_p1;
                r_acc_q <= r_acc_q + w_p2;
            end
            ssd_pkg::OP_FRND: begin
                r_x <= sat18((r_acc_i + (48'sd1 <<< SW)) >>> (SW + 1));
                r_y <= sat18((r_acc_q + (48'sd1 <<< SW)) >>> (SW + 1));
            end
            ssd_pkg::OP_ROTB: r_xr <= sat18(w_rot_add);
            ssd_pkg::OP_ROTC: r_yr <= sat18(w_rot_sub);
            ssd_pkg::OP_FAR: begin
                if (w_sub == 2'd1) begin
                    r_t1 <= MW'(w_rnd1) + w_v1a;
                    r_t2 <= MW'(w_rnd2) + w_v1b;
                end else if (w_sub == 2'd3) begin
                    if (!w_pass) begin
                        r_yi  <= sat18(w_rnd1 + WW'(w_ca));
                        r_xi1 <= sat18(w_rnd2 + WW'(w_cb));
                    end else begin
                        r_yi1 <= sat18(w_rnd1 + WW'(w_ca));
                        r_xi2 <= sat18(w_rnd2 + WW'(w_cb));
                    end
                end
            end
            ssd_pkg::OP_ERR: begin
                if (!w_out_busy) begin
                    r_et <= w_et;
                    r_ep <= w_ep;
                end
            end
            ssd_pkg::OP_NOERR: begin
                r_et <= '0;
                r_ep <= '0;
            end
            ssd_pkg::OP_LOOPC: begin
                if (w_wv < 48'sd1) r_w <= ssd_pkg::NCO_W'(1);
                else r_w <= w_wv[ssd_pkg::NCO_W-1:0];
            end
            ssd_pkg::OP_LOOPD: begin
                if (w_t[ssd_pkg::NCO_W+1]) r_rem <= r_nco;
            end
            ssd_pkg::OP_DIV: begin
                if (w_ge) r_rem <= ssd_pkg::NCO_W'(w_r2 - {1'b0, r_w});
                else r_rem <= w_r2[ssd_pkg::NCO_W-1:0];
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // ---- model state (reset to zero)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ssd_pkg::DL_DEPTH; j++) begin
                r_dl_i[j] <= '0;
                r_dl_q[j] <= '0;
            end
            for (int j = 0; j < 9; j++) r_fx[j] <= '0;
            for (int j = 0; j < 7; j++) r_fy[j] <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_prev   <= 1'b0;
            r_ti     <= '0;
            r_pi     <= '0;
            r_tle    <= '0;
            r_ple    <= '0;
            r_strobe <= 1'b0;
            r_mu     <= '0;
            r_nco    <= '0;
            r_angle  <= '0;
        end else begin
            case (i_cmd.op)
                ssd_pkg::OP_LOAD: begin
                    for (int j = ssd_pkg::DL_DEPTH - 1; j >= 2; j--) begin
                        r_dl_i[j] <= r_dl_i[j - 2];
                        r_dl_q[j] <= r_dl_q[j - 2];
                    end
                    r_dl_i[1] <= r_i1;
                    r_dl_i[0] <= r_i2;
                    r_dl_q[1] <= r_q1;
                    r_dl_q[0] <= r_q2;
                end
                ssd_pkg::OP_ERR: begin
                    if (!w_out_busy) begin
                        r_sx   <= r_xi1;
                        r_sy   <= r_yi;
                        r_prev <= w_d1;
                    end
                end
                ssd_pkg::OP_LOOPB: r_ti <= w_vt;
                ssd_pkg::OP_LOOPC: begin
                    r_pi    <= w_vp;
                    r_angle <= r_angle + ssd_pkg::ANG_W'((WW'(w_vp) + 48'sd128) >>> 8);
                    r_tle   <= r_et;
                    r_ple   <= r_ep;
                    // history shift after the interpolants used it
                    for (int j = 4; j >= 1; j--) r_fx[j] <= r_fx[j - 1];
                    r_fx[0] <= neg_half(r_xr);
                    for (int j = 8; j >= 6; j--) r_fx[j] <= r_fx[j - 1];
                    r_fx[5] <= r_xr;
                    for (int j = 3; j >= 1; j--) r_fy[j] <= r_fy[j - 1];
                    r_fy[0] <= neg_half(r_yr);
                    for (int j = 6; j >= 5; j--) r_fy[j] <= r_fy[j - 1];
                    r_fy[4] <= r_yr;
                end
                ssd_pkg::OP_LOOPD: begin
                    if (w_t[ssd_pkg::NCO_W+1]) begin
                        r_strobe <= 1'b1;
                        r_nco    <= ssd_pkg::NCO_W'(w_t + 19'sd65536);
                    end else begin
                        r_strobe <= 1'b0;
                        r_nco    <= w_t[ssd_pkg::NCO_W-1:0];
                    end
                end
                ssd_pkg::OP_DIV: r_mu <= {r_mu[ssd_pkg::MU_W-2:0], w_ge};
                default: begin
                    r_strobe <= r_strobe;
                end
            endcase
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == ssd_pkg::OP_ERR && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ssd_pkg::OP_ERR && !w_out_busy) begin
            r_out_data <= {2'b00, w_d1 ^ w_d0, w_d0 ^ r_prev, r_yi1, r_xi2};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_stat.strobe   = r_strobe;
    assign o_stat.wrap     = w_t[ssd_pkg::NCO_W+1];
    assign o_stat.out_busy = w_out_busy;

endmodule
`default_nettype wire

@@ sim/soqpsk_symbol_detector_checker.sv @@
// Stream monitor, bit-exact symbol detector predictor and result scoreboard.
`timescale 1ns / 1ps
module soqpsk_symbol_detector_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ssd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [ssd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssd_pkg::GAIN_W-1:0]     i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    localparam int QUARTER = 1024 / 4;
    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;

    typedef struct packed {
        logic [1:0]                 pad;
        logic                       bit_odd;
        logic                       bit_even;
        logic [ssd_pkg::SOFT_W-1:0] soft_q;
        logic [ssd_pkg::SOFT_W-1:0] soft_i;
    } t_symbol;

    // half of the symmetric detection filter, round(c * 2^17)
    longint tap_coef [ssd_pkg::HALF_TAPS] = '{1360, 3105, 1280, -3541, -11765, -14463, -6797,
                                              20306, 74573, 103861};

    longint quarter_wave [QUARTER+1];
    longint line_i [ssd_pkg::DL_DEPTH], line_q [ssd_pkg::DL_DEPTH];
    longint hist_x [9], hist_y [7];
    longint prev_xi1, prev_yi, t_integ, t_err, p_integ, p_err, mu, nco;
    longint gain_pp, gain_pl, gain_tp, gain_tl;
    logic   last_bit, strobe_pend;
    logic [ssd_pkg::ANG_W-1:0] angle;
    t_symbol expected_syms [$];
    int     err_count = 0;

    assign o_errors = err_count;

    function automatic longint sat(input longint v, input int w);
        longint lim;
        lim = 64'sd1 <<< (w - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint rnd(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sgn(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint sext(input longint unsigned v, input int w);
        longint unsigned m;
        m = v & ((64'd1 << w) - 1);
        if (m[w-1]) return longint'(m) - (64'sd1 <<< w);
        return longint'(m);
    endfunction

    function automatic longint lookup_sin(input int k);
        int q, r;
        q = (k / QUARTER) & 3;
        r = k % QUARTER;
        case (q)
            0: return quarter_wave[r];
            1: return quarter_wave[QUARTER - r];
            2: return -quarter_wave[r];
            default: return -quarter_wave[QUARTER - r];
        endcase
    endfunction

    function automatic longint interp(input longint v2, input longint v1, input longint c,
                                      input longint m);
        longint t;
        t = rnd(v2 * m, 16) + v1;
        t = rnd(t * m, 16) + c;
        return sat(t, 18);
    endfunction

    function automatic longint detect(input longint line [ssd_pkg::DL_DEPTH],
                                      input longint first, input longint second);
        longint win [ssd_pkg::FILTER_TAPS];
        longint acc;
        acc = 0;
        win[0] = second;
        win[1] = first;
        for (int j = 0; j < ssd_pkg::DL_DEPTH; j++) win[j+2] = line[j];
        for (int j = 0; j < ssd_pkg::HALF_TAPS; j++)
            acc += tap_coef[j] * (win[j] + win[ssd_pkg::FILTER_TAPS-1-j]);
        return sat(rnd(acc, ssd_pkg::SAMPLE_W + 1), 18);
    endfunction

    // integer Taylor series sine over one quarter, Q1.16
    initial begin
        longint unsigned x, x2, f, s;
        for (int m = 0; m <= QUARTER; m++) begin
            x  = longint'(m) * PIHALF_Q30 / QUARTER;
            x2 = (x * x) >> 30;
            f  = ONE_Q30 - x2 / 110;
            f  = ONE_Q30 - ((x2 * f) >> 30) / 72;
            f  = ONE_Q30 - ((x2 * f) >> 30) / 42;
            f  = ONE_Q30 - ((x2 * f) >> 30) / 20;
            f  = ONE_Q30 - ((x2 * f) >> 30) / 6;
            s  = ((x * f) >> 30);
            s  = (s + 8192) >> 14;
            if (s > 65536) s = 65536;
            quarter_wave[m] = longint'(s);
        end
    end

    // one sample pair through filter, derotator, interpolator and both loops
    task automatic detect_pair(input logic [ssd_pkg::IN_DATA_W-1:0] d);
        longint i1, q1, i2, q2, x, y, xr, yr, c, s, et, ep, vt, vp, w, t, ny;
        longint xi1, yi, yi1, xi2;
        int k;
        logic d0, d1;
        t_symbol sym;
        i1 = sext(d[15:0], 16);
        q1 = sext(d[31:16], 16);
        i2 = sext(d[47:32], 16);
        q2 = sext(d[63:48], 16);
        et = 0;
        ep = 0;
        xi1 = 0;
        yi = 0;
        d1 = 0;
        x = detect(line_i, i1, i2);
        y = detect(line_q, q1, q2);
        k = int'(angle) >> 6;
        s = lookup_sin(k);
        c = lookup_sin((k + 256) % 1024);
        xr = sat(rnd(x * c + y * s, 16), 18);
        yr = sat(rnd(y * c - x * s, 16), 18);

        if (strobe_pend) begin
            ny  = rnd(-yr, 1);
            yi  = interp(-ny + hist_y[0] + hist_y[1] - hist_y[2],
                         ny - hist_y[0] + hist_y[4] + hist_y[1] + hist_y[2], hist_y[5], mu);
            xi1 = interp(-hist_x[0] + hist_x[1] + hist_x[2] - hist_x[3],
                         hist_x[0] - hist_x[1] + hist_x[6] + hist_x[2] + hist_x[3],
                         hist_x[7], mu);
            yi1 = interp(-hist_y[0] + hist_y[1] + hist_y[2] - hist_y[3],
                         hist_y[0] - hist_y[1] + hist_y[5] + hist_y[2] + hist_y[3],
                         hist_y[6], mu);
            xi2 = interp(-hist_x[1] + hist_x[2] + hist_x[3] - hist_x[4],
                         hist_x[1] - hist_x[2] + hist_x[7] + hist_x[3] + hist_x[4],
                         hist_x[8], mu);
            et = sgn(xi2) * (xi1 - prev_xi1) + sgn(yi1) * (yi - prev_yi);
            ep = sgn(xi2) * prev_yi - sgn(yi1) * xi1;
            d0 = xi2 > 0;
            d1 = yi1 > 0;
            sym.pad      = '0;
            sym.soft_i   = xi2[ssd_pkg::SOFT_W-1:0];
            sym.soft_q   = yi1[ssd_pkg::SOFT_W-1:0];
            sym.bit_even = d0 ^ last_bit;
            sym.bit_odd  = d1 ^ d0;
            expected_syms.push_back(sym);
        end

        vt = sat(t_integ + rnd(gain_tp * et + gain_tl * t_err, 15), 24);
        vp = sat(p_integ + rnd(gain_pp * ep + gain_pl * p_err, 15), 24);
        w  = 32768 + rnd(vt, 8);
        if (w < 1) w = 1;

        for (int j = ssd_pkg::DL_DEPTH - 1; j >= 2; j--) begin
            line_i[j] = line_i[j-2];
            line_q[j] = line_q[j-2];
        end
        line_i[1] = i1;
        line_i[0] = i2;
        line_q[1] = q1;
        line_q[0] = q2;

        // -x/2 taps then x taps, same for y
        for (int j = 4; j >= 1; j--) hist_x[j] = hist_x[j-1];
        hist_x[0] = rnd(-xr, 1);
        for (int j = 8; j >= 6; j--) hist_x[j] = hist_x[j-1];
        hist_x[5] = xr;
        for (int j = 3; j >= 1; j--) hist_y[j] = hist_y[j-1];
        hist_y[0] = rnd(-yr, 1);
        for (int j = 6; j >= 5; j--) hist_y[j] = hist_y[j-1];
        hist_y[4] = yr;

        if (strobe_pend) begin
            prev_xi1 = xi1;
            prev_yi  = yi;
            last_bit = d1;
        end
        p_integ = vp;
        p_err   = ep;
        t_integ = vt;
        t_err   = et;

        // NCO underflow marks the next pair as a strobe
        t = nco - w;
        if (t < 0) begin
            strobe_pend = 1'b1;
            mu  = ((nco <<< 16) / w) & 64'hFFFF;
            nco = 65536 + t;
        end else begin
            strobe_pend = 1'b0;
            nco = t;
        end
        angle = angle + ssd_pkg::ANG_W'(rnd(vp, 8));
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol got, want;
        if (!i_rst_n) begin
            for (int j = 0; j < ssd_pkg::DL_DEPTH; j++) begin
                line_i[j] = 0;
                line_q[j] = 0;
            end
            for (int j = 0; j < 9; j++) hist_x[j] = 0;
            for (int j = 0; j < 7; j++) hist_y[j] = 0;
            prev_xi1 = 0; prev_yi = 0; t_integ = 0; t_err = 0; p_integ = 0; p_err = 0;
            mu = 0; nco = 0; angle = '0; last_bit = 0; strobe_pend = 0;
            gain_pp = 0; gain_pl = 0; gain_tp = 0; gain_tl = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ssd_pkg::CFG_PHASE_PROP:  gain_pp = sext(i_cfg_data, ssd_pkg::GAIN_W);
                    ssd_pkg::CFG_PHASE_LAG:   gain_pl = sext(i_cfg_data, ssd_pkg::GAIN_W);
                    ssd_pkg::CFG_TIMING_PROP: gain_tp = sext(i_cfg_data, ssd_pkg::GAIN_W);
                    ssd_pkg::CFG_TIMING_LAG:  gain_tl = sext(i_cfg_data, ssd_pkg::GAIN_W);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) detect_pair(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_syms.size() == 0) begin
                    $display("%0t: unexpected symbol: expected none, actual %h", $time, got);
                    err_count++;
                end else begin
                    want = expected_syms.pop_front();
                    check_field("soft_i", sext(want.soft_i, ssd_pkg::SOFT_W),
                                sext(got.soft_i, ssd_pkg::SOFT_W));
                    check_field("soft_q", sext(want.soft_q, ssd_pkg::SOFT_W),
                                sext(got.soft_q, ssd_pkg::SOFT_W));
                    check_field("bit_even", want.bit_even, got.bit_even);
                    check_field("bit_odd", want.bit_odd, got.bit_odd);
                    check_field("pad", want.pad, got.pad);
                end
            end
        end
        o_pending = expected_syms.size();
    end

endmodule

@@ sim/soqpsk_symbol_detector_test.sv @@
// Stimulus, handshake pacing and verdict for the SOQPSK symbol detector.
`timescale 1ns / 1ps
module soqpsk_symbol_detector_test;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 80;
    localparam int  HOLD_OFF    = 3000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic [ssd_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [ssd_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ssd_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ssd_pkg::GAIN_W-1:0]         cfg_data = '0;
    int                                 errors, pending;
    int                                 tx_idle_pct = 0, rx_idle_pct = 0;
    int                                 cycles = 0;
    logic                               hold_req = 1'b0;
    logic                               hold_used = 1'b0;
    int                                 hold_cnt = 0;

    soqpsk_symbol_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    soqpsk_symbol_detector_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side pacing, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_cnt  <= HOLD_OFF;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_pair(input logic [ssd_pkg::IN_DATA_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
    endtask

    // valid stays up across back-to-back writes; set_gains drops it at the end
    task automatic write_gain(input logic [ssd_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ssd_pkg::GAIN_W'(value);
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic set_gains(input int pp, input int pl, input int tp, input int tl);
        write_gain(ssd_pkg::CFG_PHASE_PROP, pp);
        write_gain(ssd_pkg::CFG_PHASE_LAG, pl);
        write_gain(ssd_pkg::CFG_TIMING_PROP, tp);
        write_gain(ssd_pkg::CFG_TIMING_LAG, tl);
        cfg_valid <= 1'b0;
    endtask

    // let the last item finish and every symbol drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1, 2:    return 16'($urandom);
            default: return 16'($signed($urandom_range(16000)) - 8000);
        endcase
    endfunction

    // mostly a bounded QPSK-like constellation with noise, some full-range noise
    task automatic send_random(input int count);
        logic [15:0] ia, qa, ib, qb;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) != 0) begin
                ia = $urandom_range(1) ? 16'sd9000 : -16'sd9000;
                qa = $urandom_range(1) ? 16'sd9000 : -16'sd9000;
                ib = ia + 16'($signed($urandom_range(2000)) - 1000);
                qb = qa + 16'($signed($urandom_range(2000)) - 1000);
            end else begin
                ia = pick_sample();
                qa = pick_sample();
                ib = pick_sample();
                qb = pick_sample();
            end
            send_pair({qb, ib, qa, ia});
        end
    endtask

    initial begin
        logic [15:0] v;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes with the loops open
        set_gains(0, 0, 0, 0);
        for (int j = 0; j < 20; j++) begin
            case (j % 5)
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h0000;
                3: v = 16'hFFFF;
                default: v = (j & 1) ? 16'h5555 : 16'hAAAA;
            endcase
            send_pair((j < 10) ? {v, v, v, v} : {~v, v, ~v, v});
        end
        drain();

        // extreme gains, eager sender, busy receiver
        set_gains(131071, -131072, 131071, -131072);
        tx_idle_pct = 6;
        rx_idle_pct = 80;
        send_random(300);
        drain();

        // moderate loop gains, roles swapped
        set_gains(2400, -2300, 9000, -8800);
        tx_idle_pct = 80;
        rx_idle_pct = 6;
        send_random(300);
        drain();

        // opposite extremes, no idling, long result hold-off
        set_gains(-131072, 131071, -131072, 131071);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        send_random(300);
        drain();

        set_gains(800, -750, 3000, -2950);
        send_random(330);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ssd_pkg.sv
rtl/ssd_ctrl.sv
rtl/ssd_datapath.sv
rtl/soqpsk_symbol_detector.sv
sim/soqpsk_symbol_detector_checker.sv
sim/soqpsk_symbol_detector_test.sv
